FILE: rtl/cpu_process_scheduler_defines.svh
// Assertion macros used by the scheduler top level.
`ifndef CPU_PROCESS_SCHEDULER_DEFINES_SVH
`define CPU_PROCESS_SCHEDULER_DEFINES_SVH

// Antecedent implies consequent in the same cycle.
`define CPS_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("scheduler assertion failed");

// Antecedent implies consequent in the next cycle.
`define CPS_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("scheduler assertion failed");

`endif

FILE: rtl/cps_pkg.sv
// Types, constants and codes of the process scheduler.
package cps_pkg;

  localparam int SLOTS = 32;
  localparam int IW    = $clog2(SLOTS);
  localparam int CW    = $clog2(SLOTS + 1);

  localparam logic REG_POLICY  = 1'b0;
  localparam logic REG_QUANTUM = 1'b1;

  localparam logic [1:0] OP_ADD     = 2'd0;
  localparam logic [1:0] OP_STEP    = 2'd1;
  localparam logic [1:0] OP_RESTART = 2'd2;
  localparam logic [1:0] OP_CLEAR   = 2'd3;

  localparam logic [2:0] POL_FCFS = 3'd0;
  localparam logic [2:0] POL_SJF  = 3'd1;
  localparam logic [2:0] POL_SRTF = 3'd2;
  localparam logic [2:0] POL_PRIO = 3'd3;
  localparam logic [2:0] POL_RR   = 3'd4;

  localparam logic [2:0] KIND_ADDED = 3'd0;
  localparam logic [2:0] KIND_FULL  = 3'd1;
  localparam logic [2:0] KIND_DISP  = 3'd2;
  localparam logic [2:0] KIND_IDLE  = 3'd3;
  localparam logic [2:0] KIND_DONE  = 3'd4;
  localparam logic [2:0] KIND_ACK   = 3'd5;

  localparam logic [2:0] CMD_NONE    = 3'd0;
  localparam logic [2:0] CMD_ADD     = 3'd1;
  localparam logic [2:0] CMD_RUN     = 3'd2;
  localparam logic [2:0] CMD_RESTART = 3'd3;
  localparam logic [2:0] CMD_CLEAR   = 3'd4;

  typedef struct packed {
    logic [2:0]    code;
    logic [IW-1:0] idx;
    logic [14:0]   arr;
    logic [3:0]    prio;
    logic [7:0]    burst;
    logic [7:0]    run;
    logic [15:0]   clock;
  } cmd_t;

  typedef struct packed {
    logic [2:0]    mode;
    logic [15:0]   clock;
    logic [IW-1:0] pos;
  } scan_t;

  typedef struct packed {
    logic          found;
    logic [IW-1:0] idx;
    logic [14:0]   arr;
    logic [3:0]    prio;
    logic [7:0]    burst;
    logic [7:0]    rem;
    logic          ge_found;
    logic [IW-1:0] ge_idx;
    logic          fa_found;
    logic [IW-1:0] fa_idx;
    logic          unf;
    logic          nx_found;
    logic [14:0]   nx_arr;
  } tok_t;

  typedef struct packed {
    logic [14:0] arr;
    logic [7:0]  burst;
    logic [7:0]  rem;
    logic        started;
    logic [15:0] first;
  } slot_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [5:0]  job_id;
    logic [15:0] slice_start;
    logic [7:0]  slice_units;
    logic        finished;
    logic [15:0] time_now;
    logic [15:0] wait_time;
    logic [15:0] turnaround;
    logic [15:0] response;
  } res_t;

endpackage

FILE: rtl/cps_cell.sv
// One table slot: holds a job and folds it into the passing scan token.
module cps_cell import cps_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic [IW-1:0] idx_i,
  input  cmd_t          cmd_i,
  input  scan_t         scan_i,
  input  tok_t          tok_i,
  output tok_t          tok_o,
  output slot_t         slot_o
);

  logic        valid_q, started_q;
  logic [14:0] arr_q;
  logic [3:0]  prio_q;
  logic [7:0]  burst_q, rem_q;
  logic [15:0] first_q;
  logic        hit, unf, elig, beats;
  tok_t        tok_d;

  assign hit = (cmd_i.idx == idx_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q   <= 1'b0;
      started_q <= 1'b0;
    end else begin
      unique case (cmd_i.code)
        CMD_ADD: if (hit) begin
          valid_q   <= 1'b1;
          started_q <= 1'b0;
        end
        CMD_RUN: if (hit) started_q <= 1'b1;
        CMD_RESTART: if (valid_q) started_q <= 1'b0;
        CMD_CLEAR: begin
          valid_q   <= 1'b0;
          started_q <= 1'b0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (cmd_i.code)
      CMD_ADD: if (hit) begin
        arr_q   <= cmd_i.arr;
        prio_q  <= cmd_i.prio;
        burst_q <= cmd_i.burst;
        rem_q   <= cmd_i.burst;
      end
      CMD_RUN: if (hit) begin
        rem_q <= rem_q - cmd_i.run;
        if (!started_q) first_q <= cmd_i.clock;
      end
      CMD_RESTART: if (valid_q) rem_q <= burst_q;
      default: ;
    endcase
  end

  assign unf  = valid_q && (rem_q != 8'd0);
  assign elig = unf && ({1'b0, arr_q} <= scan_i.clock);

  always_comb begin
    unique case (scan_i.mode)
      POL_SJF:  beats = (burst_q < tok_i.burst) ||
                        ((burst_q == tok_i.burst) && (arr_q < tok_i.arr));
      POL_SRTF: beats = (rem_q < tok_i.rem) ||
                        ((rem_q == tok_i.rem) && (arr_q < tok_i.arr));
      POL_PRIO: beats = (prio_q > tok_i.prio) ||
                        ((prio_q == tok_i.prio) && (arr_q < tok_i.arr));
      default:  beats = (arr_q < tok_i.arr);
    endcase
  end

  always_comb begin
    tok_d = tok_i;
    if (elig && (!tok_i.found || beats)) begin
      tok_d.found = 1'b1;
      tok_d.idx   = idx_i;
      tok_d.arr   = arr_q;
      tok_d.prio  = prio_q;
      tok_d.burst = burst_q;
      tok_d.rem   = rem_q;
    end
    if (elig && !tok_i.ge_found && (idx_i >= scan_i.pos)) begin
      tok_d.ge_found = 1'b1;
      tok_d.ge_idx   = idx_i;
    end
    if (elig && !tok_i.fa_found) begin
      tok_d.fa_found = 1'b1;
      tok_d.fa_idx   = idx_i;
    end
    tok_d.unf = tok_i.unf | unf;
    if (unf && ({1'b0, arr_q} > scan_i.clock) &&
        (!tok_i.nx_found || (arr_q < tok_i.nx_arr))) begin
      tok_d.nx_found = 1'b1;
      tok_d.nx_arr   = arr_q;
    end
  end

  always_ff @(posedge clk_i) begin
    tok_o <= tok_d;
  end

  assign slot_o = '{arr: arr_q, burst: burst_q, rem: rem_q, started: started_q,
                    first: first_q};

endmodule

FILE: rtl/cpu_process_scheduler.sv
// Process scheduler top level: control, slot chain and output register.
// Add, restart and clear: the result is registered, then moved to the output register once it is free.
// Schedule step: states SCAN, DECIDE and OUT; the scan token walks the slot chain one cell a cycle.
// One item at a time; the next is taken once the current result sits in the output register.
// Reset clears the table, clock, sweep state and registers (policy fcfs, quantum 2).
module cpu_process_scheduler import cps_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_index_i,
  input  logic [3:0]  cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  in_opcode_i,
  input  logic [14:0] in_arrival_time_i,
  input  logic [3:0]  in_job_priority_i,
  input  logic [7:0]  in_burst_length_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  out_result_kind_o,
  output logic [5:0]  out_job_id_o,
  output logic [15:0] out_slice_start_o,
  output logic [7:0]  out_slice_units_o,
  output logic        out_job_finished_o,
  output logic [15:0] out_time_now_o,
  output logic [15:0] out_wait_time_o,
  output logic [15:0] out_turnaround_o,
  output logic [15:0] out_response_o
);

`include "cpu_process_scheduler_defines.svh"

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SCAN   = 2'd1;
  localparam logic [1:0] ST_DECIDE = 2'd2;
  localparam logic [1:0] ST_OUT    = 2'd3;

  localparam tok_t TOK_INIT = '0;

  logic [1:0]    state_q, state_d;
  logic [2:0]    mode_q;
  logic [3:0]    quant_q;
  logic [15:0]   clock_q, clock_d;
  logic [CW-1:0] fill_q, fill_d;
  logic [IW-1:0] pos_q, pos_d, cnt_q, cnt_d;
  logic          prog_q, prog_d;
  logic          out_valid_q;
  res_t          res_q, res_d, out_q;
  cmd_t          cmd;
  scan_t         scan;
  tok_t          tok_in  [SLOTS];
  tok_t          tok_out [SLOTS];
  slot_t         slots   [SLOTS];

  logic          accept, out_free;
  tok_t          tk;
  logic          disp, adv;
  logic [IW-1:0] sel;
  slot_t         ss;
  logic [7:0]    units, run;
  logic [16:0]   sum;
  logic [15:0]   nclk, ta, fs;
  logic [7:0]    burst_in;

  assign scan = '{mode: mode_q, clock: clock_q, pos: pos_q};

  for (genvar k = 0; k < SLOTS; k++) begin : g_cell
    if (k == 0) begin : g_head
      assign tok_in[k] = TOK_INIT;
    end else begin : g_link
      assign tok_in[k] = tok_out[k-1];
    end
    cps_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .idx_i  (IW'(k)),
      .cmd_i  (cmd),
      .scan_i (scan),
      .tok_i  (tok_in[k]),
      .tok_o  (tok_out[k]),
      .slot_o (slots[k])
    );
  end

  assign accept   = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != ST_IDLE);
  assign out_free = !out_valid_q || !out_stall_i;
  assign tk       = tok_out[SLOTS-1];
  assign burst_in = (in_burst_length_i == 8'd0) ? 8'd1 : in_burst_length_i;

  always_comb begin
    disp   = 1'b0;
    adv    = 1'b0;
    sel    = tk.idx;
    prog_d = prog_q;
    pos_d  = pos_q;
    units  = tk.rem;
    if (tk.unf) begin
      if (mode_q == POL_RR) begin
        units = {4'd0, (quant_q == 4'd0) ? 4'd1 : quant_q};
        if (tk.ge_found) begin
          disp = 1'b1;
          sel  = tk.ge_idx;
        end else if (prog_q && tk.fa_found) begin
          disp = 1'b1;
          sel  = tk.fa_idx;
        end else begin
          adv = 1'b1;
        end
        if (disp) begin
          prog_d = 1'b1;
          pos_d  = (sel == IW'(SLOTS - 1)) ? '0 : sel + 1'b1;
        end else begin
          prog_d = 1'b0;
          pos_d  = '0;
        end
      end else begin
        disp = tk.found;
        adv  = !tk.found;
        if (mode_q == POL_SRTF) units = 8'd1;
      end
    end
  end

  assign ss   = slots[sel];
  assign run  = (units < ss.rem) ? units : ss.rem;
  assign sum  = {1'b0, clock_q} + {9'd0, run};
  assign nclk = sum[16] ? 16'hFFFF : sum[15:0];
  assign ta   = nclk - {1'b0, ss.arr};
  assign fs   = ss.started ? ss.first : clock_q;

  always_comb begin
    state_d = state_q;
    clock_d = clock_q;
    fill_d  = fill_q;
    cnt_d   = cnt_q;
    res_d   = res_q;
    cmd     = '{code: CMD_NONE, idx: sel, arr: in_arrival_time_i,
                prio: in_job_priority_i, burst: burst_in, run: run, clock: clock_q};
    unique case (state_q)
      ST_IDLE: if (accept) begin
        res_d = '0;
        unique case (in_opcode_i)
          OP_ADD: begin
            if (fill_q == CW'(SLOTS)) begin
              res_d.kind = KIND_FULL;
            end else begin
              cmd.code     = CMD_ADD;
              cmd.idx      = fill_q[IW-1:0];
              fill_d       = fill_q + 1'b1;
              res_d.kind   = KIND_ADDED;
              res_d.job_id = 6'(fill_q) + 6'd1;
            end
            res_d.time_now = clock_q;
            state_d = ST_OUT;
          end
          OP_STEP: begin
            cnt_d   = '0;
            state_d = ST_SCAN;
          end
          OP_RESTART: begin
            cmd.code   = CMD_RESTART;
            clock_d    = '0;
            res_d.kind = KIND_ACK;
            state_d    = ST_OUT;
          end
          default: begin
            cmd.code   = CMD_CLEAR;
            clock_d    = '0;
            fill_d     = '0;
            res_d.kind = KIND_ACK;
            state_d    = ST_OUT;
          end
        endcase
      end
      ST_SCAN: begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == IW'(SLOTS - 1)) state_d = ST_DECIDE;
      end
      ST_DECIDE: begin
        state_d = ST_OUT;
        if (disp) begin
          cmd.code          = CMD_RUN;
          clock_d           = nclk;
          res_d.kind        = KIND_DISP;
          res_d.job_id      = 6'(sel) + 6'd1;
          res_d.slice_start = clock_q;
          res_d.slice_units = run;
          if (run == ss.rem) begin
            res_d.finished   = 1'b1;
            res_d.turnaround = ta;
            res_d.wait_time  = ta - {8'd0, ss.burst};
            res_d.response   = fs - {1'b0, ss.arr};
          end
        end else if (adv) begin
          if (tk.nx_found) clock_d = {1'b0, tk.nx_arr};
          res_d.kind = KIND_IDLE;
        end else begin
          res_d.kind = KIND_DONE;
        end
        res_d.time_now = clock_d;
      end
      default: if (out_free) state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      mode_q      <= POL_FCFS;
      quant_q     <= 4'd2;
      clock_q     <= '0;
      fill_q      <= '0;
      pos_q       <= '0;
      prog_q      <= 1'b0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      clock_q <= clock_d;
      fill_q  <= fill_d;
      cnt_q   <= cnt_d;
      if (cfg_we_i) begin
        if (cfg_index_i == REG_POLICY) mode_q <= cfg_data_i[2:0];
        else quant_q <= cfg_data_i;
      end
      if (state_q == ST_DECIDE && tk.unf && mode_q == POL_RR) begin
        pos_q  <= pos_d;
        prog_q <= prog_d;
      end else if (accept && (in_opcode_i == OP_RESTART || in_opcode_i == OP_CLEAR)) begin
        pos_q  <= '0;
        prog_q <= 1'b0;
      end
      if (state_q == ST_OUT && out_free) out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
    if (state_q == ST_OUT && out_free) out_q <= res_q;
  end

  assign out_valid_o        = out_valid_q;
  assign out_result_kind_o  = out_q.kind;
  assign out_job_id_o       = out_q.job_id;
  assign out_slice_start_o  = out_q.slice_start;
  assign out_slice_units_o  = out_q.slice_units;
  assign out_job_finished_o = out_q.finished;
  assign out_time_now_o     = out_q.time_now;
  assign out_wait_time_o    = out_q.wait_time;
  assign out_turnaround_o   = out_q.turnaround;
  assign out_response_o     = out_q.response;

  `CPS_ASSERT_IMP(a_fill_bound, 1'b1, fill_q <= CW'(SLOTS))
  `CPS_ASSERT_NXT(a_busy_after_accept, accept, state_q != ST_IDLE)
  `CPS_ASSERT_IMP(a_disp_has_id, out_valid_o && out_result_kind_o == KIND_DISP,
                  out_job_id_o != 6'd0)
  `CPS_ASSERT_IMP(a_finish_is_disp, out_valid_o && out_job_finished_o,
                  out_result_kind_o == KIND_DISP)

endmodule

FILE: verif/tb_top.sv
// Self-checking testbench for the process scheduler: predicted results against the outputs.
`timescale 1ns / 100ps

module tb_top import cps_pkg::*; ();

  localparam int IDLE_LIMIT  = 3000;
  localparam int SETTLE      = 40;
  localparam int HOLD_CYCLES = 400;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic        cfg_index_i;
  logic [3:0]  cfg_data_i;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [1:0]  in_opcode_i;
  logic [14:0] in_arrival_time_i;
  logic [3:0]  in_job_priority_i;
  logic [7:0]  in_burst_length_i;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [2:0]  out_result_kind_o;
  logic [5:0]  out_job_id_o;
  logic [15:0] out_slice_start_o;
  logic [7:0]  out_slice_units_o;
  logic        out_job_finished_o;
  logic [15:0] out_time_now_o;
  logic [15:0] out_wait_time_o;
  logic [15:0] out_turnaround_o;
  logic [15:0] out_response_o;

  cpu_process_scheduler i_dut (.*);

  // scheduler shadow state
  bit sh_valid[SLOTS];
  int sh_arr[SLOTS];
  int sh_prio[SLOTS];
  int sh_burst[SLOTS];
  int sh_rem[SLOTS];
  bit sh_started[SLOTS];
  int sh_first[SLOTS];
  int sh_clock;
  int sh_fill;
  int sh_sweep_pos;
  bit sh_sweep_prog;
  int sh_policy;
  int sh_quantum;

  res_t pending_results[$];
  int   items_sent;
  int   results_seen = 0;
  int   errors = 0;
  int   idle_cycles = 0;
  bit   no_gaps;
  int   hold_request = 0;
  int   hold_seen = 0;
  int   hold_left = 0;
  int   stall_left = 0;
  logic [2:0] last_kind;

  function automatic bit runnable(int i);
    return sh_valid[i] && sh_rem[i] > 0 && sh_arr[i] <= sh_clock;
  endfunction

  function automatic bit wins(int i, int s, int m);
    case (m)
      1: return sh_burst[i] < sh_burst[s] ||
                (sh_burst[i] == sh_burst[s] && sh_arr[i] < sh_arr[s]);
      2: return sh_rem[i] < sh_rem[s] ||
                (sh_rem[i] == sh_rem[s] && sh_arr[i] < sh_arr[s]);
      3: return sh_prio[i] > sh_prio[s] ||
                (sh_prio[i] == sh_prio[s] && sh_arr[i] < sh_arr[s]);
      default: return sh_arr[i] < sh_arr[s];
    endcase
  endfunction

  function automatic int first_runnable(int start);
    for (int i = start; i < SLOTS; i++)
      if (runnable(i)) return i;
    return -1;
  endfunction

  function automatic void jump_to_next_arrival();
    bit found;
    int nxt;
    found = 0;
    nxt = 0;
    for (int i = 0; i < SLOTS; i++)
      if (sh_valid[i] && sh_rem[i] > 0 && sh_arr[i] > sh_clock) begin
        if (!found || sh_arr[i] < nxt) nxt = sh_arr[i];
        found = 1;
      end
    if (found && nxt > sh_clock) sh_clock = nxt;
  endfunction

  function automatic void run_slice(int s, int units, inout res_t r);
    int run;
    int ta;
    run = units < sh_rem[s] ? units : sh_rem[s];
    if (!sh_started[s]) begin
      sh_started[s] = 1;
      sh_first[s] = sh_clock;
    end
    r.kind = KIND_DISP;
    r.job_id = 6'(s + 1);
    r.slice_start = 16'(sh_clock);
    r.slice_units = 8'(run);
    sh_rem[s] -= run;
    sh_clock += run;
    if (sh_clock > 65535) sh_clock = 65535;
    if (sh_rem[s] == 0) begin
      ta = (sh_clock - sh_arr[s]) & 16'hFFFF;
      r.finished = 1'b1;
      r.wait_time = 16'(ta - sh_burst[s]);
      r.turnaround = 16'(ta);
      r.response = 16'(sh_first[s] - sh_arr[s]);
    end
  endfunction

  function automatic res_t schedule_item(logic [1:0] op, logic [14:0] a, logic [3:0] p,
                                         logic [7:0] b);
    res_t r;
    int s;
    int q;
    bit unf;
    r = '0;
    if (op == OP_ADD) begin
      if (sh_fill >= SLOTS) r.kind = KIND_FULL;
      else begin
        sh_valid[sh_fill] = 1;
        sh_arr[sh_fill] = int'(a);
        sh_prio[sh_fill] = int'(p);
        sh_burst[sh_fill] = (b == 8'd0) ? 1 : int'(b);
        sh_rem[sh_fill] = sh_burst[sh_fill];
        sh_started[sh_fill] = 0;
        sh_first[sh_fill] = 0;
        sh_fill++;
        r.kind = KIND_ADDED;
        r.job_id = 6'(sh_fill);
      end
    end else if (op == OP_STEP) begin
      unf = 0;
      for (int i = 0; i < SLOTS; i++)
        if (sh_valid[i] && sh_rem[i] > 0) unf = 1;
      if (!unf) r.kind = KIND_DONE;
      else if (sh_policy == POL_RR) begin
        q = (sh_quantum == 0) ? 1 : sh_quantum;
        s = first_runnable(sh_sweep_pos);
        if (s < 0 && sh_sweep_prog) begin
          sh_sweep_prog = 0;
          s = first_runnable(0);
        end
        if (s < 0) begin
          jump_to_next_arrival();
          sh_sweep_pos = 0;
          sh_sweep_prog = 0;
          r.kind = KIND_IDLE;
        end else begin
          sh_sweep_prog = 1;
          sh_sweep_pos = (s + 1) % SLOTS;
          run_slice(s, q, r);
        end
      end else begin
        s = -1;
        for (int i = 0; i < SLOTS; i++)
          if (runnable(i) && (s < 0 || wins(i, s, sh_policy))) s = i;
        if (s < 0) begin
          jump_to_next_arrival();
          r.kind = KIND_IDLE;
        end else run_slice(s, (sh_policy == POL_SRTF) ? 1 : sh_rem[s], r);
      end
    end else begin
      for (int i = 0; i < SLOTS; i++) begin
        if (op == OP_CLEAR) begin
          sh_valid[i] = 0;
          sh_started[i] = 0;
        end else if (sh_valid[i]) begin
          sh_rem[i] = sh_burst[i];
          sh_started[i] = 0;
        end
      end
      if (op == OP_CLEAR) sh_fill = 0;
      sh_clock = 0;
      sh_sweep_pos = 0;
      sh_sweep_prog = 0;
      r.kind = KIND_ACK;
    end
    r.time_now = 16'(sh_clock);
    return r;
  endfunction

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // input side
  task automatic send_item(input logic [1:0] op, input logic [14:0] a, input logic [3:0] p,
                           input logic [7:0] b);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 16);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i        <= 1'b1;
    in_opcode_i       <= op;
    in_arrival_time_i <= a;
    in_job_priority_i <= p;
    in_burst_length_i <= b;
    do @(posedge clk_i); while (in_stall_o);
    pending_results.push_back(schedule_item(op, a, p, b));
    last_kind = pending_results[$].kind;
    items_sent++;
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic idx, input logic [3:0] data);
    wait_drained();
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == REG_POLICY) sh_policy = int'(data & 4'h7);
    else sh_quantum = int'(data);
  endtask

  task automatic add_job(input int amax, input int bmax);
    send_item(OP_ADD, 15'($urandom_range(0, amax)), 4'($urandom_range(0, 15)),
              8'($urandom_range(0, bmax)));
  endtask

  // one well-formed job set run until the table reports all done or the step cap is reached
  task automatic run_workload(input int jobs, input int amax, input int bmax, input int cap);
    int steps;
    send_item(OP_CLEAR, 15'($urandom), 4'($urandom), 8'($urandom));
    repeat (jobs) add_job(amax, bmax);
    steps = 0;
    do begin
      case ($urandom_range(0, 39))
        0: send_item(OP_RESTART, 15'($urandom), 4'($urandom), 8'($urandom));
        1: add_job(amax, bmax);
        2: send_item(2'($urandom_range(0, 3)), 15'($urandom), 4'($urandom), 8'($urandom));
        default: send_item(OP_STEP, 15'($urandom), 4'($urandom), 8'($urandom));
      endcase
      steps++;
    end while (!(last_kind == KIND_DONE) && steps < cap);
  endtask

  task automatic test_directed();
    send_item(OP_STEP, '0, '0, '0);
    send_item(OP_ADD, 15'h7FFF, 4'hF, 8'hFF);
    send_item(OP_ADD, '0, '0, '0);
    send_item(OP_ADD, '0, '0, 8'd1);
    send_item(OP_ADD, 15'd5, 4'hA, 8'h55);
    send_item(OP_STEP, '0, '0, '0);
    send_item(OP_STEP, '0, '0, '0);
    send_item(OP_STEP, '0, '0, '0);
    send_item(OP_STEP, '0, '0, '0);
    send_item(OP_STEP, '0, '0, '0);
    send_item(OP_RESTART, 15'h7FFF, 4'hF, 8'hFF);
    send_item(OP_STEP, '0, '0, '0);
    send_item(OP_CLEAR, 15'h7FFF, 4'hF, 8'hFF);
    for (int i = 0; i < SLOTS + 2; i++) send_item(OP_ADD, 15'(i & 1), 4'(i & 15), 8'd2);
    write_reg(REG_QUANTUM, 4'd0);
    write_reg(REG_POLICY, 4'(POL_RR));
    run_workload(3, 4, 3, 20);
    write_reg(REG_POLICY, 4'd7);
    run_workload(3, 4, 3, 20);
    write_reg(REG_POLICY, 4'd13);
    run_workload(2, 2, 2, 10);
  endtask

  task automatic test_policies();
    int amax;
    while (items_sent < 1850) begin
      write_reg(REG_POLICY, 4'($urandom_range(0, 7)));
      write_reg(REG_QUANTUM, ($urandom_range(0, 4) == 0) ? 4'd15 : 4'($urandom_range(0, 15)));
      no_gaps = ($urandom_range(0, 4) == 0);
      amax = ($urandom_range(0, 9) == 0) ? 32767 : 40;
      if ($urandom_range(0, 11) == 0) run_workload($urandom_range(20, 34), amax, 255, 60);
      else run_workload($urandom_range(1, 10), amax, $urandom_range(1, 8), 60);
    end
    no_gaps = 0;
  endtask

  task automatic test_backpressure();
    wait_drained();
    hold_request++;
    repeat (8) add_job(20, 4);
    repeat (8) send_item(OP_STEP, '0, '0, '0);
  endtask

  task automatic test_sender_pause();
    wait_drained();
    repeat (6) send_item(OP_STEP, '0, '0, '0);
  endtask

  // output side: compare, then choose the next stall
  function automatic void cmp(string name, int exp, int act);
    if (exp != act) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp, act);
      errors++;
    end
  endfunction

  always @(posedge clk_i) begin
    res_t e;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        results_seen++;
        stall_left <= no_gaps ? 0 : $urandom_range(0, 16);
        if (pending_results.size() == 0) begin
          $display("%0t: unexpected result, kind %0d", $time, out_result_kind_o);
          errors++;
        end else begin
          e = pending_results.pop_front();
          cmp("result_kind", int'(e.kind), int'(out_result_kind_o));
          cmp("job_id", int'(e.job_id), int'(out_job_id_o));
          cmp("slice_start", int'(e.slice_start), int'(out_slice_start_o));
          cmp("slice_units", int'(e.slice_units), int'(out_slice_units_o));
          cmp("job_finished", int'(e.finished), int'(out_job_finished_o));
          cmp("time_now", int'(e.time_now), int'(out_time_now_o));
          cmp("wait_time", int'(e.wait_time), int'(out_wait_time_o));
          cmp("turnaround", int'(e.turnaround), int'(out_turnaround_o));
          cmp("response", int'(e.response), int'(out_response_o));
        end
      end else if (stall_left > 0) stall_left <= stall_left - 1;
      if (hold_seen != hold_request) begin
        hold_seen <= hold_request;
        hold_left <= HOLD_CYCLES;
      end else if (hold_left > 0) hold_left <= hold_left - 1;
      if (hold_left > 0) out_stall_i <= 1'b1;
      else out_stall_i <= (stall_left > 1) || (out_valid_o && !out_stall_i && !no_gaps);
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles", IDLE_LIMIT);
      $display("end of test: mismatches");
      $finish;
    end
  end

  initial begin
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_index_i = 1'b0;
    cfg_data_i = '0;
    in_valid_i = 1'b0;
    in_opcode_i = '0;
    in_arrival_time_i = '0;
    in_job_priority_i = '0;
    in_burst_length_i = '0;
    items_sent = 0;
    no_gaps = 0;
    last_kind = '0;
    sh_clock = 0;
    sh_fill = 0;
    sh_sweep_pos = 0;
    sh_sweep_prog = 0;
    sh_policy = 0;
    sh_quantum = 2;
    for (int i = 0; i < SLOTS; i++) begin
      sh_valid[i] = 0;
      sh_started[i] = 0;
    end
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_backpressure();
    test_sender_pause();
    test_policies();
    wait_drained();
    $display("covered %0d items and %0d results over all five policies, quanta 0 to 15,",
             items_sent, results_seen);
    $display("table overflow, restart, clear, long output hold-off and sender pauses");
    if (errors == 0) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end

endmodule

FILE: files.f
+incdir+rtl
rtl/cps_pkg.sv
rtl/cps_cell.sv
rtl/cpu_process_scheduler.sv
verif/tb_top.sv
